FILE: rtl/core/assert_macros.svh
// assertion macros shared by the link controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define BSLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define BSLC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/bslc_pkg.sv
// types, codes and sizes shared by the link controller modules
`default_nettype none

package bslc_pkg;

  // per-destination counter table, power of two so the slot is a mask
  localparam int ADDRESS_COUNT = 256;
  localparam int SLOT_BITS = $clog2(ADDRESS_COUNT);

  // largest chunk of a send, and largest delivered frame
  localparam logic [3:0] CHUNK_BYTES = 4'd10;

  // front to back op queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  // request commands
  localparam logic [1:0] CMD_SEND  = 2'd0;
  localparam logic [1:0] CMD_RECV  = 2'd1;
  localparam logic [1:0] CMD_FRAME = 2'd2;

  // arrived frame types
  localparam logic [1:0] FT_TOKEN = 2'd0;
  localparam logic [1:0] FT_DATA  = 2'd1;
  localparam logic [1:0] FT_ACK   = 2'd2;

  // response kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_FINISH  = 2'd2;
  localparam logic [1:0] KIND_DELIVER = 2'd3;

  // configuration register indexes
  localparam logic CFG_STATION   = 1'b0;
  localparam logic CFG_BROADCAST = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_TOKEN,
    MODE_ACK,
    MODE_RECV
  } mode_t;

  // work handed from front to back
  typedef enum logic [2:0] {
    OP_FINISH,
    OP_DATA_UNI,
    OP_DATA_BC,
    OP_UNDO,
    OP_RECV
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  addr;    // send target, or source of a received frame
    logic [7:0]  num;     // received frame number
    logic [15:0] count;   // chunk, bytes sent, or bytes delivered
    logic [15:0] offset;  // chunk offset
    logic        flag;    // broadcast chunk ends the send, or frame is for us
  } op_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  target_address;
    logic [15:0] send_length;
    logic [1:0]  frame_type;
    logic [7:0]  frame_source;
    logic [7:0]  frame_destination;
    logic [7:0]  frame_number;
    logic [3:0]  frame_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  dest_address;
    logic [7:0]  src_address;
    logic [7:0]  seq_number;
    logic [15:0] byte_count;
    logic [15:0] data_offset;
    logic [7:0]  sender_address;
    logic        was_broadcast;
    logic        last;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/bus_slave_link_controller.sv
// Top level: link controller for a token bus slave, one request beat per cycle
// while the op queue is not full. The first response beat passes the op queue,
// the execute stage and the response register. A two-beat op holds the back end's
// execute stage for both beats, and a 4-entry op queue absorbs that.
// Reset (synchronous): idle mode, empty queue and response register, station 1,
// broadcast 255; all sequence counters read as zero, no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module bus_slave_link_controller (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire bslc_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output bslc_pkg::rsp_t      rsp,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic           cfg_index,
  input  wire logic [7:0]     cfg_data
);

  logic [7:0] station_address;
  logic [7:0] broadcast_address;

  logic                q_push;
  bslc_pkg::op_entry_t q_push_data;
  logic                q_pop;
  bslc_pkg::op_entry_t q_head;
  bslc_pkg::q_status_t q_status;
  logic                accept;

  assign cfg_ready = 1'b1;
  assign req_ready = !q_status.full;
  assign accept    = req_valid && req_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      station_address   <= 8'd1;
      broadcast_address <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bslc_pkg::CFG_STATION:   station_address   <= cfg_data;
        bslc_pkg::CFG_BROADCAST: broadcast_address <= cfg_data;
        default:                 station_address   <= station_address;
      endcase
    end
  end

  bslc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .req               (req),
    .station_address   (station_address),
    .broadcast_address (broadcast_address),
    .push              (q_push),
    .push_data         (q_push_data)
  );

  bslc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  bslc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (!q_status.empty),
    .head            (q_head),
    .pop             (q_pop),
    .station_address (station_address),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .rsp             (rsp)
  );

  // checks
  `BSLC_ASSERT_ALWAYS(a_rsp_idle_after_reset, $past(rst) |-> !rsp_valid, "response valid after reset")
  `BSLC_ASSERT(a_queue_holds_push, q_push && !q_pop |=> !q_status.empty, "pushed op lost from queue")
  `BSLC_ASSERT(a_second_beat_follows, rsp_valid && rsp_ready && !rsp.last |=> rsp_valid, "second response beat missing")

endmodule

`default_nettype wire

FILE: rtl/core/bslc_front.sv
// front end: mode state machine that classifies request beats into ops
`default_nettype none

module bslc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire bslc_pkg::req_t     req,
  input  wire logic [7:0]         station_address,
  input  wire logic [7:0]         broadcast_address,
  output logic                    push,
  output bslc_pkg::op_entry_t     push_data
);

  bslc_pkg::mode_t mode, mode_next;
  logic [7:0]  send_target, send_target_next;
  logic [15:0] send_total, send_total_next;
  logic [15:0] bytes_sent, bytes_sent_next;
  logic [3:0]  chunk_length, chunk_length_next;

  logic [15:0] remaining;
  logic [3:0]  chunk;
  logic [15:0] sent_plus_chunk;
  logic [15:0] sent_plus_acked;
  logic [3:0]  frame_len_sat;
  logic        is_frame;
  logic        mine;
  logic        bcast;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= bslc_pkg::MODE_IDLE;
      send_target  <= '0;
      send_total   <= '0;
      bytes_sent   <= '0;
      chunk_length <= '0;
    end else begin
      mode         <= mode_next;
      send_target  <= send_target_next;
      send_total   <= send_total_next;
      bytes_sent   <= bytes_sent_next;
      chunk_length <= chunk_length_next;
    end
  end

  // chunk sizing and address matches
  always_comb begin
    remaining = send_total - bytes_sent;
    if (remaining > {12'd0, bslc_pkg::CHUNK_BYTES}) begin
      chunk = bslc_pkg::CHUNK_BYTES;
    end else begin
      chunk = remaining[3:0];
    end
    sent_plus_chunk = bytes_sent + {12'd0, chunk};
    sent_plus_acked = bytes_sent + {12'd0, chunk_length};
    if (req.frame_length > bslc_pkg::CHUNK_BYTES) begin
      frame_len_sat = bslc_pkg::CHUNK_BYTES;
    end else begin
      frame_len_sat = req.frame_length;
    end
    is_frame = (req.cmd == bslc_pkg::CMD_FRAME);
    mine     = (req.frame_destination == station_address);
    bcast    = (req.frame_destination == broadcast_address);
  end

  // next state and op generation
  always_comb begin
    mode_next         = mode;
    send_target_next  = send_target;
    send_total_next   = send_total;
    bytes_sent_next   = bytes_sent;
    chunk_length_next = chunk_length;
    push              = 1'b0;
    push_data         = '0;
    push_data.op      = bslc_pkg::OP_FINISH;

    if (accept) begin
      if (req.cmd == bslc_pkg::CMD_SEND) begin
        send_target_next  = req.target_address;
        send_total_next   = req.send_length;
        bytes_sent_next   = '0;
        chunk_length_next = '0;
        if (req.send_length == 16'd0) begin
          // empty send finishes at once
          mode_next = bslc_pkg::MODE_IDLE;
          push      = 1'b1;
        end else begin
          mode_next = bslc_pkg::MODE_TOKEN;
        end
      end else if (req.cmd == bslc_pkg::CMD_RECV) begin
        mode_next = bslc_pkg::MODE_RECV;
      end else begin
        case (mode)
          bslc_pkg::MODE_TOKEN: begin
            if (is_frame && req.frame_type == bslc_pkg::FT_TOKEN && mine) begin
              push             = 1'b1;
              push_data.addr   = send_target;
              push_data.count  = {12'd0, chunk};
              push_data.offset = bytes_sent;
              if (send_target != broadcast_address) begin
                push_data.op      = bslc_pkg::OP_DATA_UNI;
                chunk_length_next = chunk;
                mode_next         = bslc_pkg::MODE_ACK;
              end else begin
                push_data.op    = bslc_pkg::OP_DATA_BC;
                push_data.flag  = (sent_plus_chunk == send_total);
                bytes_sent_next = sent_plus_chunk;
                if (sent_plus_chunk == send_total) begin
                  mode_next = bslc_pkg::MODE_IDLE;
                end
              end
            end
          end
          bslc_pkg::MODE_ACK: begin
            if (is_frame && req.frame_type == bslc_pkg::FT_ACK) begin
              bytes_sent_next = sent_plus_acked;
              if (sent_plus_acked == send_total) begin
                mode_next       = bslc_pkg::MODE_IDLE;
                push            = 1'b1;
                push_data.count = sent_plus_acked;
              end else begin
                mode_next = bslc_pkg::MODE_TOKEN;
              end
            end else begin
              // missing ack: undo the counter bump and end early
              mode_next       = bslc_pkg::MODE_IDLE;
              push            = 1'b1;
              push_data.op    = bslc_pkg::OP_UNDO;
              push_data.addr  = send_target;
              push_data.count = bytes_sent;
            end
          end
          bslc_pkg::MODE_RECV: begin
            if (is_frame && req.frame_type == bslc_pkg::FT_DATA && (mine || bcast)) begin
              mode_next       = bslc_pkg::MODE_IDLE;
              push            = 1'b1;
              push_data.op    = bslc_pkg::OP_RECV;
              push_data.addr  = req.frame_source;
              push_data.num   = req.frame_number;
              push_data.count = {12'd0, frame_len_sat};
              push_data.flag  = mine;
            end
          end
          default: begin
            mode_next = mode;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bslc_queue.sv
// short fifo of ops between the front end and the back end
`default_nettype none

module bslc_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire bslc_pkg::op_entry_t push_data,
  input  wire logic                pop,
  output bslc_pkg::op_entry_t      head,
  output bslc_pkg::q_status_t      status
);

  bslc_pkg::op_entry_t entries [bslc_pkg::QUEUE_DEPTH];
  logic [bslc_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [bslc_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [bslc_pkg::QPTR_BITS:0]   count;

  // storage, written at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head         = entries[rd_ptr];
  assign status.full  = (count == (bslc_pkg::QPTR_BITS + 1)'(bslc_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

`default_nettype wire

FILE: rtl/core/bslc_back.sv
// back end: sequence counter table, op execution and response register
`default_nettype none

module bslc_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                head_valid,
  input  wire bslc_pkg::op_entry_t head,
  output logic                     pop,
  input  wire logic [7:0]          station_address,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output bslc_pkg::rsp_t           rsp
);

  // counter table, entries read as zero until first written
  logic [7:0] seq_mem [bslc_pkg::ADDRESS_COUNT];
  logic [bslc_pkg::ADDRESS_COUNT-1:0] seq_written;

  // execute stage
  logic                b_valid;
  bslc_pkg::op_entry_t b_op;
  logic [7:0]          b_seq;
  logic                b_phase;

  logic                b_fire;
  logic                b_final;
  logic                two_beat;
  logic                wr_en;
  logic [7:0]          wr_data;
  bslc_pkg::rsp_t      beat;

  logic [bslc_pkg::SLOT_BITS-1:0] head_slot;
  logic [bslc_pkg::SLOT_BITS-1:0] b_slot;

  assign head_slot = head.addr[bslc_pkg::SLOT_BITS-1:0];
  assign b_slot    = b_op.addr[bslc_pkg::SLOT_BITS-1:0];

  assign b_fire  = b_valid && (!rsp_valid || rsp_ready);
  assign b_final = b_phase || !two_beat;
  assign pop     = head_valid && (!b_valid || (b_fire && b_final));

  // response beat for the current op and phase
  always_comb begin
    beat     = '0;
    two_beat = 1'b0;
    wr_en    = 1'b0;
    wr_data  = b_seq;
    case (b_op.op)
      bslc_pkg::OP_FINISH: begin
        beat.kind       = bslc_pkg::KIND_FINISH;
        beat.byte_count = b_op.count;
        beat.last       = 1'b1;
      end
      bslc_pkg::OP_DATA_UNI: begin
        wr_data           = b_seq + 8'd1;
        wr_en             = b_fire;
        beat.kind         = bslc_pkg::KIND_DATA;
        beat.dest_address = b_op.addr;
        beat.src_address  = station_address;
        beat.seq_number   = wr_data;
        beat.byte_count   = b_op.count;
        beat.data_offset  = b_op.offset;
        beat.last         = 1'b1;
      end
      bslc_pkg::OP_DATA_BC: begin
        two_beat = b_op.flag;
        if (b_phase) begin
          beat.kind       = bslc_pkg::KIND_FINISH;
          beat.byte_count = b_op.offset + b_op.count;
          beat.last       = 1'b1;
        end else begin
          beat.kind         = bslc_pkg::KIND_DATA;
          beat.dest_address = b_op.addr;
          beat.src_address  = station_address;
          beat.byte_count   = b_op.count;
          beat.data_offset  = b_op.offset;
          beat.last         = !b_op.flag;
        end
      end
      bslc_pkg::OP_UNDO: begin
        wr_data         = b_seq - 8'd1;
        wr_en           = b_fire;
        beat.kind       = bslc_pkg::KIND_FINISH;
        beat.byte_count = b_op.count;
        beat.last       = 1'b1;
      end
      bslc_pkg::OP_RECV: begin
        two_beat = b_op.flag;
        if (b_op.flag && !b_phase) begin
          beat.kind       = bslc_pkg::KIND_ACK;
          beat.seq_number = b_op.num;
        end else begin
          beat.kind           = bslc_pkg::KIND_DELIVER;
          beat.byte_count     = b_op.count;
          beat.sender_address = b_op.addr;
          beat.was_broadcast  = !b_op.flag;
          beat.last           = 1'b1;
        end
      end
      default: begin
        beat.last = 1'b1;
      end
    endcase
  end

  // counter table write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      seq_mem[b_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_written <= '0;
    end else if (wr_en) begin
      seq_written[b_slot] <= 1'b1;
    end
  end

  // counter read on pop, bypassing a write to the same slot in that cycle
  always_ff @(posedge clk) begin
    if (pop) begin
      b_op <= head;
      if (wr_en && (b_slot == head_slot)) begin
        b_seq <= wr_data;
      end else if (seq_written[head_slot]) begin
        b_seq <= seq_mem[head_slot];
      end else begin
        b_seq <= '0;
      end
    end
  end

  // execute stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_phase <= 1'b0;
    end else if (pop) begin
      b_valid <= 1'b1;
      b_phase <= 1'b0;
    end else if (b_fire) begin
      if (b_final) begin
        b_valid <= 1'b0;
        b_phase <= 1'b0;
      end else begin
        b_phase <= 1'b1;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (b_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      rsp <= beat;
    end
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for the token bus slave link controller
`default_nettype none

module testbench;
  import bslc_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] CMD_TIMEOUT = 2'd3;
  localparam logic [1:0] FT_OTHER = 2'd3;
  // quiet cycles after the last awaited beat, covers the pipe and queue
  localparam int SETTLE_CYCLES = 10;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [7:0] cfg_data;

  bus_slave_link_controller dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // link state as the testbench sees it
  mode_t link_mode;
  logic [7:0] own_station;
  logic [7:0] bcast_station;
  logic [7:0] send_dest;
  logic [15:0] send_total;
  logic [15:0] sent_so_far;
  logic [3:0] open_chunk;
  logic [7:0] seq_table [ADDRESS_COUNT];

  rsp_t pending_rsp[$];
  int error_count = 0;
  int item_count = 0;
  bit send_idle_on = 1'b1;
  bit rsp_idle_on = 1'b1;
  int rsp_hold_cycles = 0;

  // finish beat of a send
  function automatic void push_finish(logic [15:0] count);
    rsp_t b;
    b = '0;
    b.kind = KIND_FINISH;
    b.byte_count = count;
    b.last = 1'b1;
    pending_rsp.push_back(b);
  endfunction

  // apply one accepted request, queue the beats it causes; 1 if it did anything
  function automatic bit advance_link(req_t r);
    rsp_t b;
    logic [15:0] chunk;
    logic mine;
    logic to_all;
    logic [SLOT_BITS-1:0] slot;
    b = '0;
    slot = send_dest[SLOT_BITS-1:0];
    case (r.cmd)
      CMD_SEND: begin
        send_dest = r.target_address;
        send_total = r.send_length;
        sent_so_far = '0;
        open_chunk = '0;
        if (r.send_length == 16'd0) begin
          link_mode = MODE_IDLE;
          push_finish(16'd0);
        end else begin
          link_mode = MODE_TOKEN;
        end
        return 1'b1;
      end
      CMD_RECV: begin
        link_mode = MODE_RECV;
        return 1'b1;
      end
      default: ;
    endcase
    case (link_mode)
      MODE_TOKEN: begin
        if (r.cmd != CMD_FRAME || r.frame_type != FT_TOKEN ||
            r.frame_destination != own_station)
          return 1'b0;
        chunk = send_total - sent_so_far;
        if (chunk > 16'(CHUNK_BYTES))
          chunk = 16'(CHUNK_BYTES);
        b.kind = KIND_DATA;
        b.dest_address = send_dest;
        b.src_address = own_station;
        b.byte_count = chunk;
        b.data_offset = sent_so_far;
        if (send_dest != bcast_station) begin
          seq_table[slot] = seq_table[slot] + 8'd1;
          b.seq_number = seq_table[slot];
          b.last = 1'b1;
          open_chunk = chunk[3:0];
          link_mode = MODE_ACK;
          pending_rsp.push_back(b);
        end else begin
          sent_so_far = sent_so_far + chunk;
          b.last = (sent_so_far != send_total);
          pending_rsp.push_back(b);
          if (sent_so_far == send_total) begin
            link_mode = MODE_IDLE;
            push_finish(sent_so_far);
          end
        end
        return 1'b1;
      end
      MODE_ACK: begin
        if (r.cmd == CMD_FRAME && r.frame_type == FT_ACK) begin
          sent_so_far = sent_so_far + {12'd0, open_chunk};
          if (sent_so_far == send_total) begin
            link_mode = MODE_IDLE;
            push_finish(sent_so_far);
          end else begin
            link_mode = MODE_TOKEN;
          end
        end else begin
          // missing ack takes back the number
          seq_table[slot] = seq_table[slot] - 8'd1;
          link_mode = MODE_IDLE;
          push_finish(sent_so_far);
        end
        return 1'b1;
      end
      MODE_RECV: begin
        if (r.cmd != CMD_FRAME || r.frame_type != FT_DATA)
          return 1'b0;
        mine = (r.frame_destination == own_station);
        to_all = (r.frame_destination == bcast_station);
        if (!mine && !to_all)
          return 1'b0;
        if (mine) begin
          b.kind = KIND_ACK;
          b.seq_number = r.frame_number;
          pending_rsp.push_back(b);
          b = '0;
        end
        b.kind = KIND_DELIVER;
        b.byte_count = (r.frame_length > CHUNK_BYTES) ? 16'(CHUNK_BYTES) : 16'(r.frame_length);
        b.sender_address = r.frame_source;
        b.was_broadcast = !mine;
        b.last = 1'b1;
        pending_rsp.push_back(b);
        link_mode = MODE_IDLE;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // request builders, unused fields left random
  function automatic req_t any_req();
    logic [63:0] raw;
    req_t r;
    raw = {$urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    return r;
  endfunction

  function automatic req_t cmd_of(logic [1:0] code);
    req_t r;
    r = any_req();
    r.cmd = code;
    return r;
  endfunction

  function automatic req_t send_of(logic [7:0] dest, logic [15:0] len);
    req_t r;
    r = cmd_of(CMD_SEND);
    r.target_address = dest;
    r.send_length = len;
    return r;
  endfunction

  function automatic req_t frame_of(logic [1:0] ftype, logic [7:0] dst);
    req_t r;
    r = cmd_of(CMD_FRAME);
    r.frame_type = ftype;
    r.frame_destination = dst;
    return r;
  endfunction

  function automatic req_t noise_frame();
    req_t r;
    r = any_req();
    r.cmd = r.cmd[0] ? CMD_TIMEOUT : CMD_FRAME;
    return r;
  endfunction

  // one request beat; starts and ends just after a falling edge
  task automatic send_req(req_t it);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = it;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    void'(advance_link(it));
    item_count++;
    @(negedge clk);
  endtask

  // let every awaited beat come back and the pipe go quiet
  task automatic settle_link();
    req_valid = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_link_register(logic idx, logic [7:0] value);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_STATION: own_station = value;
      CFG_BROADCAST: bcast_station = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  task automatic check_rsp_beat(rsp_t got);
    rsp_t want;
    if (pending_rsp.size() == 0) begin
      error_count++;
      $display("%0t: response beat with none awaited, expected nothing got kind %0d count %0h",
               $time, got.kind, got.byte_count);
      return;
    end
    want = pending_rsp.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("dest_address", want.dest_address, got.dest_address);
    check_field("src_address", want.src_address, got.src_address);
    check_field("seq_number", want.seq_number, got.seq_number);
    check_field("byte_count", want.byte_count, got.byte_count);
    check_field("data_offset", want.data_offset, got.data_offset);
    check_field("sender_address", want.sender_address, got.sender_address);
    check_field("was_broadcast", want.was_broadcast, got.was_broadcast);
    check_field("last", want.last, got.last);
  endtask

  // response side: random stalls, optional long hold, checks every beat
  initial begin
    int stall;
    rsp_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rsp_idle_on ? $urandom_range(0, 11) : 0;
      if (rsp_hold_cycles > 0) begin
        stall = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end
      if (stall > 0) begin
        rsp_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready = 1'b1;
      do @(posedge clk); while (!rsp_valid);
      check_rsp_beat(rsp);
      @(negedge clk);
    end
  end

  // edge cases under the reset addresses (station 1, broadcast 255)
  task automatic test_directed_cases();
    req_t r;
    // idle ignores frames and timeouts
    send_req(frame_of(FT_TOKEN, 8'd1));
    send_req(cmd_of(CMD_TIMEOUT));
    // empty send finishes at once
    send_req(send_of(8'd0, 16'd0));
    // unicast of two chunks, foreign token and timeout ignored while waiting
    send_req(send_of(8'd2, 16'd20));
    send_req(frame_of(FT_TOKEN, 8'd7));
    send_req(cmd_of(CMD_TIMEOUT));
    send_req(frame_of(FT_TOKEN, 8'd1));
    send_req(frame_of(FT_ACK, 8'd0));
    send_req(frame_of(FT_TOKEN, 8'd1));
    send_req(frame_of(FT_ACK, 8'd0));
    // largest send, ack missing by timeout undoes the number
    send_req(send_of(8'd2, 16'hFFFF));
    send_req(frame_of(FT_TOKEN, 8'd1));
    send_req(cmd_of(CMD_TIMEOUT));
    // broadcast: short last chunk ends with data then finish
    send_req(send_of(8'd255, 16'd15));
    send_req(frame_of(FT_TOKEN, 8'd1));
    send_req(frame_of(FT_TOKEN, 8'd1));
    // receive abandons a send, foreign frames ignored, overlong frame saturates
    send_req(send_of(8'd9, 16'd5));
    send_req(cmd_of(CMD_RECV));
    send_req(frame_of(FT_DATA, 8'd77));
    send_req(cmd_of(CMD_TIMEOUT));
    r = frame_of(FT_DATA, 8'd1);
    r.frame_length = 4'd15;
    send_req(r);
    // broadcast delivery, empty frame
    send_req(cmd_of(CMD_RECV));
    r = frame_of(FT_DATA, 8'd255);
    r.frame_length = 4'd0;
    send_req(r);
    // new send abandons the old one, then a wrong frame type while waiting for ack
    send_req(send_of(8'd5, 16'd8));
    send_req(send_of(8'd4, 16'd12));
    send_req(frame_of(FT_TOKEN, 8'd1));
    send_req(frame_of(FT_OTHER, 8'd1));
  endtask

  // hold the response side while requests keep coming, so the block backs up
  task automatic test_output_backpressure();
    req_t r;
    settle_link();
    send_idle_on = 1'b0;
    rsp_idle_on = 1'b0;
    rsp_hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 2) begin
        send_req(cmd_of(CMD_RECV));
        r = frame_of(FT_DATA, own_station);
        send_req(r);
      end else begin
        send_req(send_of(8'($urandom), 16'd0));
      end
    end
    send_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
  endtask

  // a full send: tokens and acks, with some noise and missed acks
  task automatic send_sequence();
    req_t r;
    int pick;
    int steps;
    logic [7:0] dest;
    logic [15:0] len;
    pick = $urandom_range(0, 19);
    len = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom) : 16'($urandom_range(1, 45));
    pick = $urandom_range(0, 9);
    dest = (pick < 3) ? bcast_station : (pick == 3) ? own_station :
           (pick < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    send_req(send_of(dest, len));
    steps = 0;
    while ((link_mode == MODE_TOKEN || link_mode == MODE_ACK) && steps < 30) begin
      pick = $urandom_range(0, 19);
      if (link_mode == MODE_TOKEN) begin
        r = (pick < 3) ? noise_frame() : frame_of(FT_TOKEN, own_station);
      end else if (pick < 17) begin
        r = frame_of(FT_ACK, 8'($urandom));
      end else if (pick == 17) begin
        r = cmd_of(CMD_TIMEOUT);
      end else if (pick == 18) begin
        r = frame_of(FT_DATA, own_station);
      end else begin
        r = frame_of($urandom_range(0, 1) ? FT_TOKEN : FT_OTHER, own_station);
      end
      send_req(r);
      steps++;
    end
  endtask

  // receive mode then a data frame, sometimes with noise in between
  task automatic receive_sequence();
    req_t r;
    int pick;
    send_req(cmd_of(CMD_RECV));
    repeat ($urandom_range(0, 2)) send_req(noise_frame());
    pick = $urandom_range(0, 19);
    r = frame_of(FT_DATA, (pick < 9) ? own_station : (pick < 16) ? bcast_station :
                 8'($urandom));
    send_req(r);
  endtask

  task automatic random_traffic(int upto);
    int pick;
    while (item_count < upto) begin
      if ($urandom_range(0, 39) == 0)
        send_idle_on = !send_idle_on;
      if ($urandom_range(0, 39) == 0)
        rsp_idle_on = !rsp_idle_on;
      pick = $urandom_range(0, 19);
      if (pick < 9)
        send_sequence();
      else if (pick < 16)
        receive_sequence();
      else
        send_req(any_req());
    end
  endtask

  // several address settings, extremes included, random traffic under each
  task automatic test_config_phases();
    logic [7:0] station_set [6];
    logic [7:0] bcast_set [6];
    station_set = '{8'd0, 8'd255, 8'h5A, 8'h80, 8'($urandom), 8'd1};
    bcast_set = '{8'd255, 8'd0, 8'h5A, 8'h7F, 8'($urandom), 8'd255};
    for (int p = 0; p < 6; p++) begin
      settle_link();
      if ($urandom_range(0, 1)) begin
        write_link_register(CFG_STATION, station_set[p]);
        write_link_register(CFG_BROADCAST, bcast_set[p]);
      end else begin
        write_link_register(CFG_BROADCAST, bcast_set[p]);
        write_link_register(CFG_STATION, station_set[p]);
      end
      random_traffic(item_count + 265);
    end
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    link_mode = MODE_IDLE;
    own_station = 8'd1;
    bcast_station = 8'd255;
    send_dest = '0;
    send_total = '0;
    sent_so_far = '0;
    open_chunk = '0;
    foreach (seq_table[i]) seq_table[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_output_backpressure();
    test_config_phases();

    settle_link();
    if (error_count == 0)
      $display("bus_slave_link_controller verification clean");
    else
      $display("bus_slave_link_controller verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("bus_slave_link_controller verification failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl/core
rtl/core/bslc_pkg.sv
rtl/core/bslc_front.sv
rtl/core/bslc_queue.sv
rtl/core/bslc_back.sv
rtl/core/bus_slave_link_controller.sv
tb/testbench.sv
